// ===== rtl/pfe_pkg.sv =====
// shared types, constants and letter helpers for the playfair encryptor
package pfe_pkg;

    localparam int SQUARE_SIDE = 5;
    localparam int CELLS       = SQUARE_SIDE * SQUARE_SIDE;
    localparam int LETTERS     = 26;
    localparam int IDX_W       = 5;   // letter index 0..25
    localparam int POS_W       = 5;   // cell number 0..24
    localparam int CNT_W       = 5;   // fill count 0..25
    localparam int RC_W        = 3;   // row or column 0..4

    localparam logic [IDX_W-1:0] IDX_I    = 5'd8;
    localparam logic [IDX_W-1:0] IDX_J    = 5'd9;
    localparam logic [IDX_W-1:0] IDX_X    = 5'd23;
    localparam logic [IDX_W-1:0] IDX_LAST = 5'd25;

    localparam logic [1:0] ACT_KEY = 2'd0;
    localparam logic [1:0] ACT_MSG = 2'd1;
    localparam logic [1:0] ACT_END = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] letter;
    } item_t;

    typedef struct packed {
        logic [6:0] cipher_letter;
        logic       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CLOSE,
        ST_POS,
        ST_CELL,
        ST_LOAD
    } state_t;

    typedef struct packed {
        logic capture;
        logic key_place;
        logic walk_clear;
        logic walk_step;
        logic hold_letter;
        logic pair_load;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [1:0] action;
        logic       is_letter;
        logic       closed;
        logic       pending_valid;
        logic       walk_done;
        logic       out_free;
    } ctrl_status_t;

    // {is_letter, index}, lower case folded up and j folded to i
    function automatic logic [IDX_W:0] fold_letter(input logic [7:0] c);
        logic [7:0]       u;
        logic [7:0]       off;
        logic [IDX_W-1:0] idx;
        logic             ok;
        u   = (c >= 8'h61 && c <= 8'h7a) ? c - 8'h20 : c;
        ok  = (u >= 8'h41 && u <= 8'h5a);
        off = u - 8'h41;
        idx = off[IDX_W-1:0];
        if (idx == IDX_J)
        begin
            idx = IDX_I;
        end
        return {ok, idx};
    endfunction

    function automatic logic [RC_W-1:0] pos_row(input logic [POS_W-1:0] p);
        logic [RC_W-1:0] r;
        if (p >= POS_W'(4 * SQUARE_SIDE))
        begin
            r = 3'd4;
        end
        else if (p >= POS_W'(3 * SQUARE_SIDE))
        begin
            r = 3'd3;
        end
        else if (p >= POS_W'(2 * SQUARE_SIDE))
        begin
            r = 3'd2;
        end
        else if (p >= POS_W'(SQUARE_SIDE))
        begin
            r = 3'd1;
        end
        else
        begin
            r = 3'd0;
        end
        return r;
    endfunction

    function automatic logic [RC_W-1:0] pos_col(input logic [POS_W-1:0] p);
        logic [POS_W-1:0] base;
        logic [POS_W-1:0] diff;
        base = POS_W'(pos_row(p)) * POS_W'(SQUARE_SIDE);
        diff = p - base;
        return diff[RC_W-1:0];
    endfunction

    function automatic logic [RC_W-1:0] next_rc(input logic [RC_W-1:0] x);
        return (x == RC_W'(SQUARE_SIDE - 1)) ? '0 : x + RC_W'(1);
    endfunction

    function automatic logic [POS_W-1:0] cell_addr(input logic [RC_W-1:0] r,
                                                   input logic [RC_W-1:0] c);
        return POS_W'(r) * POS_W'(SQUARE_SIDE) + POS_W'(c);
    endfunction

    function automatic logic [6:0] to_ascii(input logic [IDX_W-1:0] idx);
        return 7'h41 + 7'(idx);
    endfunction

endpackage

// ===== rtl/pfe_ctrl.sv =====
// sequencing state machine for the playfair encryptor
module pfe_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  pfe_pkg::ctrl_status_t status,
    output pfe_pkg::ctrl_cmd_t    cmd
);

    pfe_pkg::state_t state_reg;
    pfe_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pfe_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        item_stall = (state_reg != pfe_pkg::ST_IDLE);
        unique case (state_reg)
            pfe_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = pfe_pkg::ST_DECODE;
                end
            end
            pfe_pkg::ST_DECODE:
            begin
                state_next = pfe_pkg::ST_IDLE;
                unique case (status.action) inside
                    pfe_pkg::ACT_KEY:
                    begin
                        cmd.key_place = status.is_letter;
                    end
                    pfe_pkg::ACT_MSG, pfe_pkg::ACT_END:
                    begin
                        if (!status.closed)
                        begin
                            // finish the square first, then come back here
                            cmd.walk_clear = 1'b1;
                            state_next     = pfe_pkg::ST_CLOSE;
                        end
                        else if (status.action == pfe_pkg::ACT_MSG)
                        begin
                            if (status.is_letter && !status.pending_valid)
                            begin
                                cmd.hold_letter = 1'b1;
                            end
                            else if (status.is_letter)
                            begin
                                cmd.pair_load = 1'b1;
                                state_next    = pfe_pkg::ST_POS;
                            end
                        end
                        else if (status.pending_valid)
                        begin
                            cmd.pair_load = 1'b1;
                            state_next    = pfe_pkg::ST_POS;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            pfe_pkg::ST_CLOSE:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_done)
                begin
                    state_next = pfe_pkg::ST_DECODE;
                end
            end
            pfe_pkg::ST_POS:
            begin
                state_next = pfe_pkg::ST_CELL;
            end
            pfe_pkg::ST_CELL:
            begin
                state_next = pfe_pkg::ST_LOAD;
            end
            pfe_pkg::ST_LOAD:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = pfe_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pfe_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/pfe_datapath.sv =====
// square storage, pair lookup and output buffer for the playfair encryptor
module pfe_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfe_pkg::item_t        item,
    input  pfe_pkg::ctrl_cmd_t    cmd,
    output pfe_pkg::ctrl_status_t status,
    output logic                  result_valid,
    input  logic                  result_stall,
    output pfe_pkg::result_t      result
);

    // captured item
    logic [1:0]                 act_reg;
    logic                       ok_reg;
    logic [pfe_pkg::IDX_W-1:0]  idx_reg;
    logic [pfe_pkg::IDX_W:0]    folded;

    // square state
    logic [pfe_pkg::LETTERS-1:0] used_reg;
    logic [pfe_pkg::LETTERS-1:0] used_next;
    logic [pfe_pkg::CNT_W-1:0]   fill_reg;
    logic [pfe_pkg::CNT_W-1:0]   fill_next;
    logic                        closed_reg;
    logic                        closed_next;
    logic [pfe_pkg::IDX_W-1:0]   walk_reg;
    logic [pfe_pkg::IDX_W-1:0]   walk_next;
    logic                        pv_reg;
    logic                        pv_next;
    logic [pfe_pkg::IDX_W-1:0]   pl_reg;
    logic [pfe_pkg::IDX_W-1:0]   pl_next;

    logic [pfe_pkg::IDX_W-1:0] square_mem [pfe_pkg::CELLS];
    logic [pfe_pkg::POS_W-1:0] pos_mem    [pfe_pkg::LETTERS];

    logic                       wr_en;
    logic [pfe_pkg::IDX_W-1:0]  wr_letter;
    logic [pfe_pkg::POS_W-1:0]  wr_cell;
    logic [pfe_pkg::CNT_W-1:0]  fill_eff;
    logic                       key_ok;
    logic                       walk_ok;

    // pair lookup
    logic [pfe_pkg::IDX_W-1:0]  a_reg;
    logic [pfe_pkg::IDX_W-1:0]  b_reg;
    logic                       pair_last_reg;
    logic                       same_pending;
    logic [pfe_pkg::POS_W-1:0]  pos_a_q;
    logic [pfe_pkg::POS_W-1:0]  pos_b_q;
    logic [pfe_pkg::IDX_W-1:0]  cell_a_q;
    logic [pfe_pkg::IDX_W-1:0]  cell_b_q;
    logic [pfe_pkg::RC_W-1:0]   ra;
    logic [pfe_pkg::RC_W-1:0]   ca;
    logic [pfe_pkg::RC_W-1:0]   rb;
    logic [pfe_pkg::RC_W-1:0]   cb;
    logic [pfe_pkg::POS_W-1:0]  addr_a;
    logic [pfe_pkg::POS_W-1:0]  addr_b;

    // output buffer
    logic [1:0]                 out_cnt_reg;
    logic [pfe_pkg::IDX_W-1:0]  e0_reg;
    logic [pfe_pkg::IDX_W-1:0]  e1_reg;
    logic                       out_last_reg;

    assign folded = pfe_pkg::fold_letter(item.letter);

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= item.action;
            ok_reg  <= folded[pfe_pkg::IDX_W];
            idx_reg <= folded[pfe_pkg::IDX_W-1:0];
        end
    end

    // a key letter after a closed square starts from an empty square
    assign fill_eff     = closed_reg ? '0 : fill_reg;
    assign key_ok       = ok_reg && (closed_reg || !used_reg[idx_reg])
                          && (fill_eff < pfe_pkg::CNT_W'(pfe_pkg::CELLS));
    assign walk_ok      = (walk_reg != pfe_pkg::IDX_J) && !used_reg[walk_reg]
                          && (fill_reg < pfe_pkg::CNT_W'(pfe_pkg::CELLS));
    assign same_pending = (act_reg == pfe_pkg::ACT_MSG) && (pl_reg == idx_reg);

    always_comb
    begin
        wr_en     = 1'b0;
        wr_letter = idx_reg;
        wr_cell   = fill_eff;
        if (cmd.key_place)
        begin
            wr_en = key_ok;
        end
        else if (cmd.walk_step)
        begin
            wr_en     = walk_ok;
            wr_letter = walk_reg;
            wr_cell   = fill_reg;
        end
    end

    always_comb
    begin
        used_next   = used_reg;
        fill_next   = fill_reg;
        closed_next = closed_reg;
        walk_next   = walk_reg;
        pv_next     = pv_reg;
        pl_next     = pl_reg;
        if (cmd.key_place)
        begin
            if (closed_reg)
            begin
                used_next   = '0;
                fill_next   = '0;
                closed_next = 1'b0;
                pv_next     = 1'b0;
                pl_next     = '0;
            end
            if (key_ok)
            begin
                used_next[idx_reg] = 1'b1;
                fill_next          = fill_eff + pfe_pkg::CNT_W'(1);
            end
        end
        if (cmd.walk_clear)
        begin
            walk_next = '0;
        end
        if (cmd.walk_step)
        begin
            if (walk_ok)
            begin
                used_next[walk_reg] = 1'b1;
                fill_next           = fill_reg + pfe_pkg::CNT_W'(1);
            end
            walk_next = walk_reg + pfe_pkg::IDX_W'(1);
            if (walk_reg == pfe_pkg::IDX_LAST)
            begin
                closed_next = 1'b1;
            end
        end
        if (cmd.hold_letter)
        begin
            pv_next = 1'b1;
            pl_next = idx_reg;
        end
        // a doubled letter stays held as the start of the next pair
        if (cmd.pair_load && !same_pending)
        begin
            pv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            fill_reg   <= '0;
            closed_reg <= 1'b0;
            walk_reg   <= '0;
            pv_reg     <= 1'b0;
            pl_reg     <= '0;
        end
        else
        begin
            used_reg   <= used_next;
            fill_reg   <= fill_next;
            closed_reg <= closed_next;
            walk_reg   <= walk_next;
            pv_reg     <= pv_next;
            pl_reg     <= pl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pair_load)
        begin
            a_reg         <= pl_reg;
            b_reg         <= (same_pending || act_reg == pfe_pkg::ACT_END) ?
                             pfe_pkg::IDX_X : idx_reg;
            pair_last_reg <= (act_reg == pfe_pkg::ACT_END);
        end
    end

    // memories: letter to cell and cell to letter
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            square_mem[wr_cell] <= wr_letter;
            pos_mem[wr_letter]  <= wr_cell;
        end
        pos_a_q  <= pos_mem[a_reg];
        pos_b_q  <= pos_mem[b_reg];
        cell_a_q <= square_mem[addr_a];
        cell_b_q <= square_mem[addr_b];
    end

    assign ra = pfe_pkg::pos_row(pos_a_q);
    assign ca = pfe_pkg::pos_col(pos_a_q);
    assign rb = pfe_pkg::pos_row(pos_b_q);
    assign cb = pfe_pkg::pos_col(pos_b_q);

    always_comb
    begin
        if (ra == rb)
        begin
            addr_a = pfe_pkg::cell_addr(ra, pfe_pkg::next_rc(ca));
            addr_b = pfe_pkg::cell_addr(rb, pfe_pkg::next_rc(cb));
        end
        else if (ca == cb)
        begin
            addr_a = pfe_pkg::cell_addr(pfe_pkg::next_rc(ra), ca);
            addr_b = pfe_pkg::cell_addr(pfe_pkg::next_rc(rb), cb);
        end
        else
        begin
            addr_a = pfe_pkg::cell_addr(ra, cb);
            addr_b = pfe_pkg::cell_addr(rb, ca);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
        end
        else if (cmd.out_load)
        begin
            out_cnt_reg <= 2'd2;
        end
        else if (result_valid && !result_stall)
        begin
            out_cnt_reg <= out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            e0_reg       <= cell_a_q;
            e1_reg       <= cell_b_q;
            out_last_reg <= pair_last_reg;
        end
    end

    assign result_valid         = (out_cnt_reg != 2'd0);
    assign result.cipher_letter = pfe_pkg::to_ascii((out_cnt_reg == 2'd2) ? e0_reg : e1_reg);
    assign result.last          = (out_cnt_reg == 2'd2) ? 1'b0 : out_last_reg;

    assign status.action        = act_reg;
    assign status.is_letter     = ok_reg;
    assign status.closed        = closed_reg;
    assign status.pending_valid = pv_reg;
    assign status.walk_done     = (walk_reg == pfe_pkg::IDX_LAST);
    assign status.out_free      = (out_cnt_reg == 2'd0);

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= pfe_pkg::CNT_W'(pfe_pkg::CELLS))
        else $error("fill count past square size");

    a_out_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_cnt_reg == 2'd0)
        else $error("pair loaded over undelivered letters");

    a_walk_close: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.walk_step && walk_reg == pfe_pkg::IDX_LAST) |=> closed_reg)
        else $error("square not closed after fill walk");

endmodule

// ===== rtl/playfair_cipher_encryptor.sv =====
// top level of the streaming playfair encryptor
//
// input channel item (action, letter) with item_valid / item_stall; output
// channel result (cipher_letter, last) with result_valid / result_stall.
// an item is taken at a clock edge where valid is high and stall is low.
// key items build the 5x5 square; message items are folded and paired, and
// each pair gives two cipher letters in order; end of message pads a held
// letter with x and flags the second letter with last.
// steps per item, after the accepting edge:
//   key items, ignored bytes, held first letters: decode only
//   a finished pair: decode, position read, cell read, load; both letters
//   enter the output buffer at the load, first result offered from then on
//   first message item after a key: first the 26-step walk over
//   the alphabet that fills the rest of the square, then a second decode
// the steps follow from the single-ported fill path and the registered
// reads of the position and square memories.
// stall is high while an item is in work. a held-off receiver only delays
// the next pair: items without output keep flowing, and a new pair waits
// in its last step until the two letters before it have gone.
// reset clears the square bookkeeping, held letter and output buffer; the
// square memories themselves are not cleared and are rewritten per key.
module playfair_cipher_encryptor (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  pfe_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_stall,
    output pfe_pkg::result_t result
);

    // command and status between sequencer and datapath
    pfe_pkg::ctrl_cmd_t    cmd;
    pfe_pkg::ctrl_status_t status;

    // sequencer: accepts items, runs the fill walk and pair lookup steps
    pfe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // datapath: square memories, held letter, pair lookup, output buffer
    pfe_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
